[hdl/tcna_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcna_pkg
// Shared constants, types, step functions and result format of the triangle centroid,
// normal and area pipeline.
// ----------------------------------------------------------------------------
package tcna_pkg;

    localparam int COORD_FRAC_BITS = 16;

    // floor(m / 3) == (m * RECIP3) >> RECIP_SHIFT for m < 2^RECIP_SHIFT
    localparam int          RECIP_SHIFT = 37;
    localparam logic [35:0] RECIP3      = 36'd45812984491;

    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 16;

    localparam logic [2:0] CFG_X_LOW  = 3'd0;
    localparam logic [2:0] CFG_X_HIGH = 3'd1;
    localparam logic [2:0] CFG_Y_LOW  = 3'd2;
    localparam logic [2:0] CFG_Y_HIGH = 3'd3;
    localparam logic [2:0] CFG_Z_LOW  = 3'd4;
    localparam logic [2:0] CFG_Z_HIGH = 3'd5;

    typedef struct packed {
        logic [2:0][31:0] ctr;
        logic             in_box;
        logic             degen;
        logic             wide;
        logic [2:0]       neg;
        logic [2:0][62:0] r;
    } t_side;

    typedef struct packed {
        logic [65:0]  rem;
        logic [63:0]  root;
        logic [127:0] rad;
    } t_sqrt;

    typedef struct packed {
        logic [63:0]      len;
        logic [2:0][64:0] rem;
        logic [2:0][15:0] q;
    } t_div;

    typedef struct packed {
        logic             in_box;
        logic             degen;
        logic [2:0][31:0] ctr;
        logic [2:0][15:0] nrm;
        logic [47:0]      area;
    } t_res;

    function automatic t_sqrt sqrt_step(t_sqrt s);
        t_sqrt       n;
        logic [65:0] cur;
        logic [65:0] trial;
        cur   = {s.rem[63:0], s.rad[127:126]};
        trial = {s.root, 2'b01};
        n.rad = {s.rad[125:0], 2'b00};
        if (cur >= trial) begin
            n.rem  = cur - trial;
            n.root = {s.root[62:0], 1'b1};
        end else begin
            n.rem  = cur;
            n.root = {s.root[62:0], 1'b0};
        end
        return n;
    endfunction

    function automatic t_div div_init(t_side sd, logic [63:0] len);
        t_div d;
        logic ge;
        d.len = len;
        for (int i = 0; i < 3; i++) begin
            ge = {2'b00, sd.r[i]} >= {1'b0, len};
            d.rem[i] = ge ? ({2'b00, sd.r[i]} - {1'b0, len}) : {2'b00, sd.r[i]};
            d.q[i]   = {15'd0, ge};
        end
        return d;
    endfunction

    function automatic t_div div_step(t_div d);
        t_div        n;
        logic [64:0] t;
        logic        ge;
        n.len = d.len;
        for (int i = 0; i < 3; i++) begin
            t  = {d.rem[i][63:0], 1'b0};
            ge = t >= {1'b0, d.len};
            n.rem[i] = ge ? (t - {1'b0, d.len}) : t;
            n.q[i]   = {d.q[i][14:0], ge};
        end
        return n;
    endfunction

    function automatic t_res format_result(t_side sd, t_div d);
        t_res        o;
        logic [63:0] a;
        logic [16:0] qp;
        logic [15:0] m;
        a = sd.wide ? (d.len >> (COORD_FRAC_BITS - 1)) : (d.len >> (COORD_FRAC_BITS + 1));
        o.in_box = sd.in_box;
        o.degen  = sd.degen;
        o.ctr    = sd.ctr;
        for (int i = 0; i < 3; i++) begin
            qp = {1'b0, d.q[i]} + 17'd1;
            m  = qp[16:1];
            if (sd.degen) begin
                o.nrm[i] = 16'd0;
            end else begin
                o.nrm[i] = sd.neg[i] ? (16'd0 - m) : m;
            end
        end
        if (sd.degen) begin
            o.area = 48'd0;
        end else if (|a[63:48]) begin
            o.area = {48{1'b1}};
        end else begin
            o.area = a[47:0];
        end
        return o;
    endfunction

endpackage

[hdl/triangle_centroid_normal_area.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_centroid_normal_area
// Centroid, unit normal (Q1.14), area and box test of one triangle per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with nine vertex coordinates, Q15.16.
//   A transfer happens on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with centroid, normal, area, flags.
//   Configuration: i_cfg_we writes i_cfg_data to box register i_cfg_idx;
//   indexes six and seven are dropped. Write only while the block is empty.
// Timing:
//   One triangle per cycle while o_stall is low. An input triangle passes
//   the difference, cross product, centroid and square stages, the 64-step
//   square root, the three 16-bit normal dividers, one format stage and
//   the output register before o_valid.
// Reset:
//   Synchronous, active low. Clears all valid bits and the box registers.
// Stall:
//   The output register is backed by a one-entry skid buffer. When the
//   receiver stalls, the next result goes into the skid buffer and the
//   pipeline holds only once that buffer is full; o_stall is a register.
// ----------------------------------------------------------------------------
module triangle_centroid_normal_area
    import tcna_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic signed [31:0] i_third_x,
    input  logic signed [31:0] i_third_y,
    input  logic signed [31:0] i_third_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_in_box,
    output logic               o_degenerate,
    output logic signed [31:0] o_center_x,
    output logic signed [31:0] o_center_y,
    output logic signed [31:0] o_center_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic [47:0]        o_area
);

    logic signed [31:0] r_box [0:5];

    logic signed [31:0] w_a [0:2];
    logic signed [31:0] w_b [0:2];
    logic signed [31:0] w_c [0:2];

    logic w_adv;

    // stage 1
    logic               r_v1;
    logic signed [32:0] r_u [0:2];
    logic signed [32:0] r_w [0:2];
    logic signed [33:0] r_s [0:2];
    // stage 2
    logic               r_v2;
    logic signed [65:0] r_pa [0:2];
    logic signed [65:0] r_pb [0:2];
    logic [33:0]        r_m  [0:2];
    logic [2:0]         r_cn2;
    logic [33:0]        n_abs [0:2];
    // stage 3
    logic               r_v3;
    logic signed [66:0] r_c  [0:2];
    logic [69:0]        r_cp [0:2];
    logic [2:0]         r_cn3;
    // stage 4
    logic               r_v4;
    logic [65:0]        r_mag [0:2];
    logic [2:0]         r_ng4;
    logic [31:0]        r_ctr [0:2];
    logic [66:0]        n_cneg [0:2];
    logic [31:0]        n_q [0:2];
    // stage 5
    logic               r_v5;
    t_side              r_sd5;
    t_side              n_sd5;
    logic               n_wide;
    // stage 6
    logic               r_v6;
    t_side              r_sd6;
    logic [61:0]        r_hh [0:2];
    logic [62:0]        r_hl [0:2];
    logic [63:0]        r_ll [0:2];
    // stage 7
    logic               r_v7;
    t_side              r_sd7;
    logic [127:0]       r_sqr [0:2];
    // square root
    logic               r_sq_v [0:SQRT_STEPS];
    t_sqrt              r_sq   [0:SQRT_STEPS];
    t_side              r_ss   [0:SQRT_STEPS];
    // dividers
    logic               r_dv_v [0:DIV_STEPS-1];
    t_div               r_dv   [0:DIV_STEPS-1];
    t_side              r_ds   [0:DIV_STEPS-1];
    // format, output, skid
    logic               r_fmt_v;
    t_res               r_fmt;
    logic               r_out_v;
    t_res               r_out;
    logic               r_skid_v;
    t_res               r_skid;
    logic               w_take;
    logic               w_push;

    assign w_a = '{i_first_x,  i_first_y,  i_first_z};
    assign w_b = '{i_second_x, i_second_y, i_second_z};
    assign w_c = '{i_third_x,  i_third_y,  i_third_z};

    assign w_adv   = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_box[i] <= 32'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_LOW:  r_box[0] <= i_cfg_data;
                CFG_X_HIGH: r_box[1] <= i_cfg_data;
                CFG_Y_LOW:  r_box[2] <= i_cfg_data;
                CFG_Y_HIGH: r_box[3] <= i_cfg_data;
                CFG_Z_LOW:  r_box[4] <= i_cfg_data;
                CFG_Z_HIGH: r_box[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_sd5  = r_sd5;
        n_wide = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_abs[i]  = r_s[i][33] ? (~r_s[i] + 34'd1) : r_s[i];
            n_cneg[i] = ~r_c[i] + 67'd1;
            n_q[i]    = r_cp[i][RECIP_SHIFT +: 32];
            n_wide    = n_wide | (|r_mag[i][65:63]);
        end
        n_sd5.wide   = n_wide;
        n_sd5.degen  = (r_mag[0] == 66'd0) && (r_mag[1] == 66'd0) && (r_mag[2] == 66'd0);
        n_sd5.neg    = r_ng4;
        n_sd5.in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n_sd5.r[i]   = n_wide ? r_mag[i][64:2] : r_mag[i][62:0];
            n_sd5.ctr[i] = r_ctr[i];
            if (!(($signed(r_ctr[i]) >= r_box[2*i]) && ($signed(r_ctr[i]) < r_box[2*i+1])))
                n_sd5.in_box = 1'b0;
        end
    end

    // front stages: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_v6     <= 1'b0;
            r_v7     <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_v5     <= r_v4;
            r_v6     <= r_v5;
            r_v7     <= r_v6;
            r_sq_v[0] <= r_v7;
        end
    end

    // front stages: data
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= {w_b[i][31], w_b[i]} - {w_a[i][31], w_a[i]};
                r_w[i] <= {w_c[i][31], w_c[i]} - {w_a[i][31], w_a[i]};
                r_s[i] <= {{2{w_a[i][31]}}, w_a[i]} + {{2{w_b[i][31]}}, w_b[i]}
                        + {{2{w_c[i][31]}}, w_c[i]};
                r_m[i]   <= n_abs[i] + 34'd1;
                r_cn2[i] <= r_s[i][33];
            end
            r_pa[0] <= r_u[1] * r_w[2];
            r_pb[0] <= r_u[2] * r_w[1];
            r_pa[1] <= r_u[2] * r_w[0];
            r_pb[1] <= r_u[0] * r_w[2];
            r_pa[2] <= r_u[0] * r_w[1];
            r_pb[2] <= r_u[1] * r_w[0];
            for (int i = 0; i < 3; i++) begin
                r_c[i]   <= {r_pa[i][65], r_pa[i]} - {r_pb[i][65], r_pb[i]};
                r_cp[i]  <= r_m[i] * RECIP3;
                r_mag[i] <= r_c[i][66] ? n_cneg[i][65:0] : r_c[i][65:0];
                r_ng4[i] <= r_c[i][66];
                r_ctr[i] <= r_cn3[i] ? (32'd0 - n_q[i]) : n_q[i];
                r_hh[i]  <= r_sd5.r[i][62:32] * r_sd5.r[i][62:32];
                r_hl[i]  <= r_sd5.r[i][62:32] * r_sd5.r[i][31:0];
                r_ll[i]  <= r_sd5.r[i][31:0] * r_sd5.r[i][31:0];
                r_sqr[i] <= ({66'd0, r_hh[i]} << 64) + ({65'd0, r_hl[i]} << 33)
                          + {64'd0, r_ll[i]};
            end
            r_cn3 <= r_cn2;
            r_sd5 <= n_sd5;
            r_sd6 <= r_sd5;
            r_sd7 <= r_sd6;
            r_sq[0].rem  <= 66'd0;
            r_sq[0].root <= 64'd0;
            r_sq[0].rad  <= r_sqr[0] + r_sqr[1] + r_sqr[2];
            r_ss[0]      <= r_sd7;
        end
    end

    // square root: one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[j+1] <= sqrt_step(r_sq[j]);
                r_ss[j+1] <= r_ss[j];
            end
        end
    end

    // normal dividers: one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_v[0] <= r_sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0] <= div_init(r_ss[SQRT_STEPS], r_sq[SQRT_STEPS].root);
            r_ds[0] <= r_ss[SQRT_STEPS];
        end
    end

    for (genvar j = 1; j < DIV_STEPS; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[j] <= div_step(r_dv[j-1]);
                r_ds[j] <= r_ds[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_v <= 1'b0;
        end else if (w_adv) begin
            r_fmt_v <= r_dv_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fmt <= format_result(r_ds[DIV_STEPS-1], r_dv[DIV_STEPS-1]);
        end
    end

    // output register with skid entry
    assign w_take = r_out_v && !i_stall;
    assign w_push = w_adv && r_fmt_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            r_out_v  <= r_skid_v || w_push;
            r_skid_v <= 1'b0;
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            r_out <= r_skid_v ? r_skid : r_fmt;
        end else if (w_push) begin
            r_skid <= r_fmt;
        end
    end

    assign o_valid      = r_out_v;
    assign o_in_box     = r_out.in_box;
    assign o_degenerate = r_out.degen;
    assign o_center_x   = r_out.ctr[0];
    assign o_center_y   = r_out.ctr[1];
    assign o_center_z   = r_out.ctr[2];
    assign o_normal_x   = r_out.nrm[0];
    assign o_normal_y   = r_out.nrm[1];
    assign o_normal_z   = r_out.nrm[2];
    assign o_area       = r_out.area;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output entry");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v) && $past(i_stall))
        else $error("skid entry filled while output was free");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_area == 48'd0) && (o_normal_x == 16'sd0)
            && (o_normal_y == 16'sd0) && (o_normal_z == 16'sd0))
        else $error("degenerate result with nonzero normal or area");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= 16'sd16384) && (o_normal_x >= -16'sd16384)
            && (o_normal_y <= 16'sd16384) && (o_normal_y >= -16'sd16384)
            && (o_normal_z <= 16'sd16384) && (o_normal_z >= -16'sd16384))
        else $error("normal component beyond unit length");

endmodule

[tb/triangle_centroid_normal_area_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_centroid_normal_area_tb
// Self-checking bench for the triangle centroid, normal and area pipeline.
// A directed table covers zero, extreme, right-angle and degenerate
// triangles. Random phases then sweep box settings with mixed triangle
// shapes. The sender works in bursts, the receiver stalls in patterns and
// holds off once for a long stretch. Every result is checked field by field
// against the directed table or an exact bench-side geometry model.
// ----------------------------------------------------------------------------
module triangle_centroid_normal_area_tb;
    import tcna_pkg::*;

    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [31:0] C_MAX = 32'h7fff_ffff;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE   = 32'h0001_0000;

    typedef struct packed {
        logic             in_box;
        logic             degen;
        logic [2:0][31:0] ctr;
        logic [2:0][15:0] nrm;
        logic [47:0]      area;
    } t_geom;

    typedef struct packed {
        logic             typed;
        logic [8:0][31:0] v;
        t_geom            res;
    } t_tri;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [31:0] i_v [9] = '{default: '0};
    logic o_stall, o_valid, o_in_box, o_degenerate;
    logic signed [31:0] o_center_x, o_center_y, o_center_z;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic [47:0] o_area;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    t_tri  tri_q [$];
    t_geom geom_q [$];
    int    errors = 0;
    bit    hold_req = 1'b0;

    always #4 i_clk = ~i_clk;

    triangle_centroid_normal_area i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_first_x(i_v[0]), .i_first_y(i_v[1]), .i_first_z(i_v[2]),
        .i_second_x(i_v[3]), .i_second_y(i_v[4]), .i_second_z(i_v[5]),
        .i_third_x(i_v[6]), .i_third_y(i_v[7]), .i_third_z(i_v[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_in_box(o_in_box), .o_degenerate(o_degenerate),
        .o_center_x(o_center_x), .o_center_y(o_center_y), .o_center_z(o_center_z),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_area(o_area)
    );

    function automatic void queue_row(t_tri t);
        tri_q.insert(tri_q.size(), t);
    endfunction

    function automatic logic signed [67:0] cross_comp(logic signed [67:0] a,
            logic signed [67:0] b, logic signed [67:0] c, logic signed [67:0] d);
        return a * b - c * d;
    endfunction

    function automatic t_geom triangle_geometry(logic [8:0][31:0] v);
        t_geom g;
        longint p [9];
        longint s, c;
        logic signed [67:0] u [3];
        logic signed [67:0] w [3];
        logic signed [67:0] n [3];
        logic [67:0] mag [3];
        logic [63:0] r [3];
        logic [63:0] len, t;
        logic [127:0] sum;
        logic [79:0] q;
        logic [15:0] m;
        logic [63:0] a;
        logic wide;
        for (int i = 0; i < 9; i++) p[i] = longint'(signed'(v[i]));
        g.in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            s = p[i] + p[3 + i] + p[6 + i];
            c = (s >= 0) ? (s + 1) / 3 : -((-s + 1) / 3);
            g.ctr[i] = c[31:0];
            if (!(c >= longint'(box_lo[i]) && c < longint'(box_hi[i]))) g.in_box = 1'b0;
            u[i] = p[3 + i] - p[i];
            w[i] = p[6 + i] - p[i];
        end
        n[0] = cross_comp(u[1], w[2], u[2], w[1]);
        n[1] = cross_comp(u[2], w[0], u[0], w[2]);
        n[2] = cross_comp(u[0], w[1], u[1], w[0]);
        wide = 1'b0;
        g.degen = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag[i] = n[i] < 0 ? -n[i] : n[i];
            if (mag[i] != 0) g.degen = 1'b0;
            if (mag[i] >= (68'd1 << 63)) wide = 1'b1;
        end
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            r[i] = wide ? mag[i][65:2] : mag[i][63:0];
            sum += 128'(r[i]) * 128'(r[i]);
        end
        len = '0;
        for (int b = 63; b >= 0; b--) begin
            t = len | (64'd1 << b);
            if (128'(t) * 128'(t) <= sum) len = t;
        end
        a = wide ? (len >> (COORD_FRAC_BITS - 1)) : (len >> (COORD_FRAC_BITS + 1));
        g.area = g.degen ? 48'd0 : (|a[63:48] ? {48{1'b1}} : a[47:0]);
        for (int i = 0; i < 3; i++) begin
            m = '0;
            if (!g.degen) begin
                q = {r[i], 15'd0} / {16'd0, len};
                m = 16'((q + 1) >> 1);
            end
            g.nrm[i] = (n[i] < 0) ? 16'd0 - m : m;
        end
        return g;
    endfunction

    function automatic t_tri typed_row(logic [8:0][31:0] v, logic ib, logic dg,
            logic [2:0][31:0] ctr, logic [2:0][15:0] nrm, logic [47:0] area);
        t_tri t;
        t.typed = 1'b1;
        t.v = v;
        t.res = '{in_box: ib, degen: dg, ctr: ctr, nrm: nrm, area: area};
        return t;
    endfunction

    function automatic t_tri checked_row(logic [8:0][31:0] v);
        t_tri t;
        t.typed = 1'b0;
        t.v = v;
        t.res = '0;
        return t;
    endfunction

    function automatic logic [31:0] near(int span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return C_MAX;
            1: return C_MIN;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [8:0][31:0] random_triangle(int span);
        logic [8:0][31:0] v;
        logic [31:0] d;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0, 1:    v[i] = $urandom;
                2:       v[i] = pick_extreme();
                default: v[i] = near(span);
            endcase
        end
        if (kind == 7) begin
            // collinear: second and third step along one direction
            for (int i = 0; i < 3; i++) begin
                d = near(span / 4);
                v[3 + i] = v[i] + d;
                v[6 + i] = v[i] + ($urandom_range(0, 1) ? d + d : 32'd0 - d);
            end
        end else if (kind == 8) begin
            for (int i = 0; i < 3; i++) v[6 + i] = v[3 * $urandom_range(0, 1) + i];
        end
        return v;
    endfunction

    // sender: bursts of transfers with random gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_tri cur;
        logic nv;
        if (i_valid && !o_stall) begin
            cur = tri_q.pop_front();
            geom_q.insert(geom_q.size(), cur.typed ? cur.res : triangle_geometry(cur.v));
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 60);
                gap_left = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        nv = 1'b0;
        if (gap_left > 0) begin
            gap_left--;
        end else if (i_rst_n && tri_q.size() > 0) begin
            nv = 1'b1;
            for (int i = 0; i < 9; i++) i_v[i] <= tri_q[0].v[i];
        end
        i_valid <= nv;
    end

    // receiver: stall pattern changes now and then, plus one long hold-off
    int mode = 0;
    int mode_left = 100;
    int hold_cnt = 0;
    int phase_cnt = 0;
    always @(posedge i_clk) begin
        logic st;
        if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 256);
        end else begin
            mode_left--;
        end
        phase_cnt++;
        case (mode)
            0: st = 1'b0;
            1: st = ($urandom_range(0, 3) == 0);
            2: st = ($urandom_range(0, 3) != 0);
            default: st = (phase_cnt % 5) < 2;
        endcase
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt++;
            st = 1'b1;
        end
        i_stall <= st;
    end

    // result check
    always @(posedge i_clk) begin
        t_geom e;
        if (o_valid && !i_stall) begin
            if (geom_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = geom_q.pop_front();
                if (o_in_box !== e.in_box) begin
                    $error("in_box exp %0d got %0d", e.in_box, o_in_box); errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate exp %0d got %0d", e.degen, o_degenerate); errors++;
                end
                if (o_center_x !== e.ctr[0]) begin
                    $error("center_x exp %h got %h", e.ctr[0], o_center_x); errors++;
                end
                if (o_center_y !== e.ctr[1]) begin
                    $error("center_y exp %h got %h", e.ctr[1], o_center_y); errors++;
                end
                if (o_center_z !== e.ctr[2]) begin
                    $error("center_z exp %h got %h", e.ctr[2], o_center_z); errors++;
                end
                if (o_normal_x !== e.nrm[0]) begin
                    $error("normal_x exp %h got %h", e.nrm[0], o_normal_x); errors++;
                end
                if (o_normal_y !== e.nrm[1]) begin
                    $error("normal_y exp %h got %h", e.nrm[1], o_normal_y); errors++;
                end
                if (o_normal_z !== e.nrm[2]) begin
                    $error("normal_z exp %h got %h", e.nrm[2], o_normal_z); errors++;
                end
                if (o_area !== e.area) begin
                    $error("area exp %h got %h", e.area, o_area); errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int idle_cnt = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("triangle_centroid_normal_area_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic write_box(logic [31:0] lo [3], logic [31:0] hi [3], bit spare);
        logic [2:0] idx [8];
        logic [31:0] val [8];
        int n;
        idx = '{CFG_X_LOW, CFG_X_HIGH, CFG_Y_LOW, CFG_Y_HIGH, CFG_Z_LOW, CFG_Z_HIGH,
                CFG_SPARE_6, CFG_SPARE_7};
        for (int i = 0; i < 3; i++) begin
            val[2 * i] = lo[i];
            val[2 * i + 1] = hi[i];
        end
        val[6] = $urandom;
        val[7] = $urandom;
        n = spare ? 8 : 6;
        for (int i = 0; i < n; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[i];
            i_cfg_data <= val[i];
            if (i < 6) begin
                if (i % 2 == 0) box_lo[i / 2] = val[i];
                else box_hi[i / 2] = val[i];
            end
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (tri_q.size() > 0 || i_valid || geom_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(int count, int span, bit hold);
        for (int i = 0; i < count; i++) queue_row(checked_row(random_triangle(span)));
        if (hold) begin
            @(negedge i_clk);
            hold_req = 1'b1;
        end
        drain();
    endtask

    initial begin
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [31:0] c;
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = '0;
            box_hi[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, box at reset (empty)
        queue_row(typed_row('0, 1'b0, 1'b1, '0, '0, '0));
        queue_row(typed_row({9{C_MAX}}, 1'b0, 1'b1, {3{C_MAX}}, '0, '0));
        queue_row(typed_row({9{C_MIN}}, 1'b0, 1'b1, {3{C_MIN}}, '0, '0));
        queue_row(typed_row({32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0},
            1'b0, 1'b0, {32'd0, 32'd21845, 32'd21845}, {16'd16384, 16'd0, 16'd0},
            48'd32768));
        queue_row(typed_row({32'd0, 32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0},
            1'b0, 1'b0, {32'd0, 32'd21845, 32'd21845}, {16'hc000, 16'd0, 16'd0},
            48'd32768));
        queue_row(checked_row({C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                               C_MIN, C_MAX, C_MIN}));
        queue_row(checked_row({C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                               C_MIN, C_MIN, C_MAX}));
        queue_row(checked_row({C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
                               C_MAX, C_MAX, C_MIN}));
        queue_row(checked_row({32'hffff_ffff, 32'd1, 32'd0, 32'd0, 32'hffff_ffff,
                               32'd1, 32'd1, 32'd0, 32'hffff_ffff}));
        queue_row(checked_row({32'hffff_fffe, 32'hffff_ffff, 32'd5, 32'd0, 32'd0,
                               32'd7, 32'd0, 32'd0, 32'd0}));
        queue_row(checked_row({C_MAX, C_MAX, 32'd0, C_MIN, 32'd0, C_MIN,
                               32'd0, C_MIN, C_MAX}));
        queue_row(checked_row({32'd3, 32'd2, 32'd1, 32'd9, 32'd4, 32'd1,
                               32'd6, 32'd3, 32'd1}));
        drain();

        // full-range box, some directed rows again, then random triangles
        for (int i = 0; i < 3; i++) begin
            lo[i] = C_MIN;
            hi[i] = C_MAX;
        end
        write_box(lo, hi, 1'b1);
        queue_row(checked_row({9{C_MAX}}));
        queue_row(checked_row({9{C_MIN}}));
        queue_row(checked_row({32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE,
                               32'd0, 32'd0, 32'd0}));
        random_phase(390, 1 << 30, 1'b0);

        // small box around the origin, small triangles, long hold-off
        for (int i = 0; i < 3; i++) begin
            lo[i] = near(1 << 22) - (1 << 23);
            hi[i] = near(1 << 22) + (1 << 23);
        end
        write_box(lo, hi, 1'b0);
        random_phase(390, 1 << 24, 1'b1);

        // inverted and empty boxes
        for (int i = 0; i < 3; i++) begin
            c = near(1 << 20);
            lo[i] = c + ONE;
            hi[i] = (i == 0) ? c + ONE : c;
        end
        write_box(lo, hi, 1'b1);
        random_phase(390, 1 << 20, 1'b0);

        // random box bounds
        for (int i = 0; i < 3; i++) begin
            lo[i] = $urandom;
            hi[i] = $urandom;
            if (signed'(lo[i]) > signed'(hi[i])) begin
                c = lo[i];
                lo[i] = hi[i];
                hi[i] = c;
            end
        end
        write_box(lo, hi, 1'b0);
        random_phase(390, 1 << 29, 1'b0);

        // box touching the extremes on the low side only
        for (int i = 0; i < 3; i++) begin
            lo[i] = C_MIN;
            hi[i] = near(1 << 16);
        end
        write_box(lo, hi, 1'b1);
        random_phase(390, 1 << 18, 1'b0);

        if (errors == 0) begin
            $display("triangle_centroid_normal_area_tb: done, clean");
        end else begin
            $display("triangle_centroid_normal_area_tb: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
hdl/tcna_pkg.sv
hdl/triangle_centroid_normal_area.sv
tb/triangle_centroid_normal_area_tb.sv
